### rtl/core/spq_pkg.sv
// Shared types and codes for the stable priority queue.
package spq_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned OccW   = 5;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 56;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic            valid;
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] count;
  } entry_t;

  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } ctrl_t;

endpackage

### rtl/core/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts toward its neighbors.
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  ctrl_t  ctrl_i,
  input  entry_t prev_entry_i,
  input  logic   prev_keep_i,
  input  entry_t next_entry_i,
  output logic   keep_o,
  output entry_t entry_o,
  output entry_t entry_d_o
);

  logic            valid_q, valid_d;
  logic [IdW-1:0]  id_q, id_d;
  logic [KeyW-1:0] count_q, count_d;

  // The entry stays when it ranks at or above the incoming key.
  assign keep_o = valid_q && (count_q >= ctrl_i.key);

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    count_d = count_q;
    if (ctrl_i.ins && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        id_d    = ctrl_i.id;
        count_d = ctrl_i.key;
      end else begin
        valid_d = prev_entry_i.valid;
        id_d    = prev_entry_i.id;
        count_d = prev_entry_i.count;
      end
    end else if (ctrl_i.rem) begin
      valid_d = next_entry_i.valid;
      id_d    = next_entry_i.id;
      count_d = next_entry_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    count_q <= count_d;
  end

  assign entry_o   = '{valid: valid_q, id: id_q, count: count_q};
  assign entry_d_o = '{valid: valid_d, id: id_d, count: count_d};

endmodule

### rtl/core/stable_priority_queue.sv
// Top level of the stable priority queue: cell chain, fill count and result register.
//
//   Channel  | Direction | Carries
//   s_axis   | in        | tuser: cmd; tdata: cust_id, ticket_count
//   m_axis   | out       | tuser: status; tdata: removed and head entries, occupancy
//
// Each transfer updates the whole cell chain at once, so one item per cycle while the output is not stalled.
// The result is registered and appears the cycle after the input transfer.
// A new input is taken while the result register is empty or being drained.
// Reset empties the queue at once; no clearing pass is needed.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // cust_id[15:0], ticket_count[23:16]
  input  logic                s_axis_tuser_i,  // cmd[0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,  // removed_valid[0], removed_id[16:1],
                                               // removed_count[24:17], head_valid[25],
                                               // head_id[41:26], head_count[49:42],
                                               // occupancy[54:50], zero[55]
  output logic [1:0]          m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            ent_q [DEPTH];
  entry_t            ent_d [DEPTH];
  logic [DEPTH-1:0]  keep;
  logic [DEPTH-1:0]  vld;
  ctrl_t             ctrl;
  logic              accept, is_rem, full, empty;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW+4:0]   occ_ext;

  logic              out_vld_q;
  status_e           status_q, status_d;
  entry_t            rem_q, rem_d;
  entry_t            head_q, head_d;
  logic [OccW-1:0]   occ_q;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign is_rem = (cmd_e'(s_axis_tuser_i) == CMD_REMOVE);
  assign full   = vld[DEPTH-1];
  assign empty  = !vld[0];

  assign ctrl.ins = accept && !is_rem && !full;
  assign ctrl.rem = accept && is_rem && !empty;
  assign ctrl.id  = s_axis_tdata_i[IdW-1:0];
  assign ctrl.key = s_axis_tdata_i[IdW+KeyW-1:IdW];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_k;
    if (i == 0) begin : g_first
      assign prev_e = '0;
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = ent_q[i-1];
      assign prev_k = keep[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_body
      assign next_e = ent_q[i+1];
    end
    spq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_entry_i(prev_e),
      .prev_keep_i (prev_k),
      .next_entry_i(next_e),
      .keep_o      (keep[i]),
      .entry_o     (ent_q[i]),
      .entry_d_o   (ent_d[i])
    );
    assign vld[i] = ent_q[i].valid;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl.ins) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (ctrl.rem) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  assign occ_ext = {5'b0, cnt_d};

  always_comb begin
    status_d = ST_DONE;
    if (!is_rem && full) begin
      status_d = ST_FULL;
    end else if (is_rem && empty) begin
      status_d = ST_EMPTY;
    end
    rem_d  = ctrl.rem ? ent_q[0] : '0;
    head_d = ent_d[0].valid ? ent_d[0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rem_q    <= rem_d;
      head_q   <= head_d;
      occ_q    <= occ_ext[OccW-1:0];
    end
  end

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = status_q;
  assign m_axis_tdata_o  = {1'b0, occ_q, head_q.count, head_q.id, head_q.valid,
                            rem_q.count, rem_q.id, rem_q.valid};

`ifndef SYNTH
  a_cnt_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == CntW'($countones(vld)))
    else $error("fill count differs from occupied cells");

  a_cells_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld >> 1) & ~vld) == '0)
    else $error("occupied cells are not a prefix of the chain");

  a_removal_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && rem_q.valid) |-> (status_q == ST_DONE))
    else $error("removed entry reported with a failure status");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the stable priority queue with directed rows and random traffic.
module testbench;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned RAND_ITEMS = 1500;
  localparam int unsigned LONG_HOLD  = 300;
  localparam int unsigned DRAIN_WAIT = 10;
  localparam longint unsigned LIMIT  = 1_000_000;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] count;
  } ticket_t;

  typedef struct packed {
    status_e         status;
    logic            rem_valid;
    logic [IdW-1:0]  rem_id;
    logic [KeyW-1:0] rem_count;
    logic            head_valid;
    logic [IdW-1:0]  head_id;
    logic [KeyW-1:0] head_count;
    logic [OccW-1:0] occ;
  } outcome_t;

  typedef struct packed {
    cmd_e            cmd;
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
    logic [4:0]      reps;
    logic            typed;
    outcome_t        want;
  } row_t;

  localparam outcome_t FROM_MODEL = '0;
  localparam int unsigned NROWS = 13;

  // Typed rows cover reset, the emptied queue and the extreme keys; the rest come from
  // the queue model, including ties, the full queue and stable removal order.
  localparam row_t PLAN [NROWS] = '{
    '{CMD_REMOVE, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{ST_EMPTY, 1'b0, 16'h0000, 8'h00, 1'b0, 16'h0000, 8'h00, 5'd0}},
    '{CMD_INSERT, 16'hFFFF, 8'hFF, 5'd1,  1'b1,
      '{ST_DONE,  1'b0, 16'h0000, 8'h00, 1'b1, 16'hFFFF, 8'hFF, 5'd1}},
    '{CMD_REMOVE, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{ST_DONE,  1'b1, 16'hFFFF, 8'hFF, 1'b0, 16'h0000, 8'h00, 5'd0}},
    '{CMD_INSERT, 16'h0000, 8'h00, 5'd1,  1'b1,
      '{ST_DONE,  1'b0, 16'h0000, 8'h00, 1'b1, 16'h0000, 8'h00, 5'd1}},
    '{CMD_INSERT, 16'h0001, 8'h00, 5'd1,  1'b0, FROM_MODEL},
    '{CMD_INSERT, 16'hAAAA, 8'h55, 5'd1,  1'b0, FROM_MODEL},
    '{CMD_INSERT, 16'h5555, 8'hAA, 5'd1,  1'b0, FROM_MODEL},
    '{CMD_INSERT, 16'h0100, 8'h55, 5'd1,  1'b0, FROM_MODEL},
    '{CMD_INSERT, 16'h0200, 8'hFF, 5'd1,  1'b0, FROM_MODEL},
    '{CMD_INSERT, 16'h1000, 8'h80, 5'd10, 1'b0, FROM_MODEL},
    '{CMD_INSERT, 16'hFFFF, 8'hFF, 5'd1,  1'b0, FROM_MODEL},
    '{CMD_INSERT, 16'h0000, 8'h00, 5'd1,  1'b0, FROM_MODEL},
    '{CMD_REMOVE, 16'hFFFF, 8'hFF, 5'd3,  1'b0, FROM_MODEL}
  };

  logic                clk_i = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [InDataW-1:0]  in_data;
  logic                in_user;
  logic                out_valid;
  logic                out_ready;
  logic [OutDataW-1:0] out_data;
  logic [1:0]          out_user;

  ticket_t  ranking[$];
  outcome_t due_results[$];
  bit       steady;
  bit       rx_hold_req;
  int       errors;
  int       n_insert, n_remove, n_full, n_empty, n_checked, peak_occ;
  longint unsigned cycles;

  always #5 clk_i = ~clk_i;

  stable_priority_queue #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .s_axis_tuser_i (in_user),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .m_axis_tuser_o (out_user)
  );

  function automatic outcome_t queue_step(cmd_e cmd, logic [IdW-1:0] id, logic [KeyW-1:0] key);
    outcome_t o;
    ticket_t  t;
    int       pos;
    o = '0;
    o.status = ST_DONE;
    if (cmd == CMD_INSERT) begin
      if (ranking.size() >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < ranking.size() && ranking[pos].count >= key) pos++;
        t.id = id;
        t.count = key;
        ranking.insert(pos, t);
      end
    end else if (ranking.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      t = ranking.pop_front();
      o.rem_valid = 1'b1;
      o.rem_id = t.id;
      o.rem_count = t.count;
    end
    if (ranking.size() > 0) begin
      o.head_valid = 1'b1;
      o.head_id = ranking[0].id;
      o.head_count = ranking[0].count;
    end
    o.occ = OccW'(ranking.size());
    return o;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
    return $urandom_range(1, 3);
  endfunction

  task automatic offer(cmd_e cmd, logic [IdW-1:0] id, logic [KeyW-1:0] key,
                       logic typed, outcome_t want);
    outcome_t predicted;
    int       pause;
    in_valid <= 1'b1;
    in_data  <= {key, id};
    in_user  <= cmd;
    do @(posedge clk_i); while (!in_ready);
    predicted = queue_step(cmd, id, key);
    due_results.push_back(typed ? want : predicted);
    if (cmd == CMD_INSERT) n_insert++;
    else n_remove++;
    if (predicted.status == ST_FULL) n_full++;
    if (predicted.status == ST_EMPTY) n_empty++;
    if (ranking.size() > peak_occ) peak_occ = ranking.size();
    pause = 0;
    if (!steady && $urandom_range(0, 9) >= 6) pause = idle_len();
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
                 $time, out_user, out_data);
      end else begin
        want = due_results.pop_front();
        n_checked++;
        check_field("status",        want.status,     out_user);
        check_field("removed_valid", want.rem_valid,  out_data[0]);
        check_field("removed_id",    want.rem_id,     out_data[16:1]);
        check_field("removed_count", want.rem_count,  out_data[24:17]);
        check_field("head_valid",    want.head_valid, out_data[25]);
        check_field("head_id",       want.head_id,    out_data[41:26]);
        check_field("head_count",    want.head_count, out_data[49:42]);
        check_field("occupancy",     want.occ,        out_data[54:50]);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end
    end
  end

  initial begin
    int          sent, phase, span, mode, ins_pct, r;
    logic [7:0]  tie_base;
    logic [7:0]  key;
    cmd_e        cmd;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    in_user  = 1'b0;
    steady   = 1'b0;
    rx_hold_req = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NROWS; i++) begin
      for (int k = 0; k < PLAN[i].reps; k++) begin
        offer(PLAN[i].cmd, PLAN[i].id + IdW'(k), PLAN[i].key, PLAN[i].typed, PLAN[i].want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      span     = $urandom_range(20, 120);
      mode     = $urandom_range(0, 3);
      tie_base = 8'($urandom_range(0, 253));
      steady   = ($urandom_range(0, 4) == 0);
      case (mode)
        0: ins_pct = 85;
        1: ins_pct = 15;
        2: ins_pct = 50;
        default: ins_pct = 55;
      endcase
      if (phase == 3) rx_hold_req = 1'b1;
      if (phase == 6) wait_drained();
      for (int k = 0; k < span; k++) begin
        cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
        r = $urandom_range(0, 9);
        if (mode == 3) key = tie_base + 8'($urandom_range(0, 2));
        else if (r == 0) key = 8'h00;
        else if (r == 1) key = 8'hFF;
        else key = 8'($urandom_range(0, 255));
        offer(cmd, 16'($urandom_range(0, 65535)), key, 1'b0, FROM_MODEL);
        sent++;
      end
      phase++;
    end

    steady = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("testbench: %0d inserts (%0d rejected as full), %0d removes (%0d on empty)",
             n_insert, n_full, n_remove, n_empty);
    $display("testbench: %0d results checked over %0d phases, peak occupancy %0d",
             n_checked, phase, peak_occ);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
